FILE: sv/assert_macros.svh
// Assertion macros shared by the clearance test RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Check that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

FILE: sv/spct_pkg.sv
// Package for the segment pair clearance test: payload types and constants.
// No dependencies.
`timescale 1ns / 1ps
package spct_pkg;
  localparam int GridSideDefault = 1024;
  localparam int CoordW = 10;
  localparam int SafeW = 11;

  typedef struct packed {
    logic [CoordW-1:0] agent1_x;
    logic [CoordW-1:0] agent1_y;
    logic [CoordW-1:0] goal1_x;
    logic [CoordW-1:0] goal1_y;
    logic [CoordW-1:0] agent2_x;
    logic [CoordW-1:0] agent2_y;
    logic [CoordW-1:0] goal2_x;
    logic [CoordW-1:0] goal2_y;
  } in_item_t;

  typedef struct packed {
    logic separable;
    logic segments_cross;
    logic ends_both_close;
    logic clearance_met;
  } out_item_t;

  // Pipeline advance control handed to every stage.
  typedef struct packed {
    logic adv;
  } pipe_ctrl_t;
endpackage

FILE: sv/spct_dist.sv
// One endpoint-to-segment clearance check, three register stages.
// Depends on spct_pkg for widths; advances on the shared pipeline enable.
`timescale 1ns / 1ps
module spct_dist (
  input  logic                     clk,
  input  spct_pkg::pipe_ctrl_t     ctrl,
  input  logic [spct_pkg::CoordW-1:0] px,
  input  logic [spct_pkg::CoordW-1:0] py,
  input  logic [spct_pkg::CoordW-1:0] ax,
  input  logic [spct_pkg::CoordW-1:0] ay,
  input  logic [spct_pkg::CoordW-1:0] bx,
  input  logic [spct_pkg::CoordW-1:0] by,
  input  logic [spct_pkg::SafeW-1:0]  s,
  output logic                     far
);
  localparam int DW = spct_pkg::CoordW + 1;
  localparam int PW = 2 * DW + 1;

  // Stage 1: differences and pairwise products.
  logic signed [DW-1:0] abx, aby, apx, apy, bpx, bpy;
  assign abx = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign aby = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign apx = $signed({1'b0, px}) - $signed({1'b0, ax});
  assign apy = $signed({1'b0, py}) - $signed({1'b0, ay});
  assign bpx = $signed({1'b0, px}) - $signed({1'b0, bx});
  assign bpy = $signed({1'b0, py}) - $signed({1'b0, by});

  logic signed [PW-1:0] len2, dot, ap2, bp2, crs;
  logic [2*spct_pkg::SafeW-1:0] s2;
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      len2 <= PW'(abx * abx) + PW'(aby * aby);
      dot  <= PW'(abx * apx) + PW'(aby * apy);
      ap2  <= PW'(apx * apx) + PW'(apy * apy);
      bp2  <= PW'(bpx * bpx) + PW'(bpy * bpy);
      crs  <= PW'(abx * apy) - PW'(aby * apx);
      s2   <= s * s;
    end
  end

  // Stage 2: pick the case and square the cross term.
  localparam int QW = 2 * PW;
  logic [QW-1:0] cr2, rhs_a;
  logic [PW-1:0] len2_r;
  logic [2*spct_pkg::SafeW-1:0] s2_r;
  logic sel_pt, pt_ok;
  logic [PW-1:0] crs_abs;
  assign crs_abs = crs[PW-1] ? PW'(-crs) : PW'(crs);
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      sel_pt <= (len2 == '0) || dot < 0 || dot > len2;
      pt_ok  <= ((len2 == '0) || dot < 0) ? ($unsigned(ap2) >= PW'(s2))
                                           : ($unsigned(bp2) >= PW'(s2));
      cr2    <= crs_abs * crs_abs;
      len2_r <= len2;
      s2_r   <= s2;
    end
  end

  // Stage 3: product of squared clearance and squared length, then the final compare.
  assign rhs_a = QW'(s2_r) * QW'(len2_r);
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      far <= sel_pt ? pt_ok : (cr2 >= rhs_a);
    end
  end
endmodule

FILE: sv/spct_cross.sv
// Segment intersection test by orientation signs, three register stages.
// Depends on spct_pkg for widths; advances on the shared pipeline enable.
`timescale 1ns / 1ps
module spct_cross (
  input  logic                 clk,
  input  spct_pkg::pipe_ctrl_t ctrl,
  input  spct_pkg::in_item_t   it,
  output logic                 meet
);
  localparam int DW = spct_pkg::CoordW + 1;
  localparam int PW = 2 * DW + 1;

  typedef struct packed {
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
  } prod_pair_t;

  function automatic prod_pair_t turn_prod(
    input logic [spct_pkg::CoordW-1:0] px, py, qx, qy, rx, ry);
    prod_pair_t r;
    r.a = PW'(($signed({1'b0, qy}) - $signed({1'b0, py})) *
              ($signed({1'b0, rx}) - $signed({1'b0, qx})));
    r.b = PW'(($signed({1'b0, qx}) - $signed({1'b0, px})) *
              ($signed({1'b0, ry}) - $signed({1'b0, qy})));
    return r;
  endfunction

  function automatic logic in_box(
    input logic [spct_pkg::CoordW-1:0] px, py, qx, qy, rx, ry);
    logic ox, oy;
    ox = (px < rx) ? (qx >= px && qx <= rx) : (qx >= rx && qx <= px);
    oy = (py < ry) ? (qy >= py && qy <= ry) : (qy >= ry && qy <= py);
    return ox && oy;
  endfunction

  // Stage 1: products and bounding-box flags.
  prod_pair_t p1, p2, p3, p4;
  logic [3:0] box;
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      p1 <= turn_prod(it.agent1_x, it.agent1_y, it.goal1_x, it.goal1_y,
                      it.agent2_x, it.agent2_y);
      p2 <= turn_prod(it.agent1_x, it.agent1_y, it.goal1_x, it.goal1_y,
                      it.goal2_x, it.goal2_y);
      p3 <= turn_prod(it.agent2_x, it.agent2_y, it.goal2_x, it.goal2_y,
                      it.agent1_x, it.agent1_y);
      p4 <= turn_prod(it.agent2_x, it.agent2_y, it.goal2_x, it.goal2_y,
                      it.goal1_x, it.goal1_y);
      box[0] <= in_box(it.agent1_x, it.agent1_y, it.agent2_x, it.agent2_y,
                       it.goal1_x, it.goal1_y);
      box[1] <= in_box(it.agent1_x, it.agent1_y, it.goal2_x, it.goal2_y,
                       it.goal1_x, it.goal1_y);
      box[2] <= in_box(it.agent2_x, it.agent2_y, it.agent1_x, it.agent1_y,
                       it.goal2_x, it.goal2_y);
      box[3] <= in_box(it.agent2_x, it.agent2_y, it.goal1_x, it.goal1_y,
                       it.goal2_x, it.goal2_y);
    end
  end

  // Stage 2: compare products to get orientation codes.
  logic [3:0] zero, pos;
  logic [3:0] box_r;
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      zero  <= {p4.a == p4.b, p3.a == p3.b, p2.a == p2.b, p1.a == p1.b};
      pos   <= {p4.a > p4.b, p3.a > p3.b, p2.a > p2.b, p1.a > p1.b};
      box_r <= box;
    end
  end

  // Stage 3: combine general and collinear cases.
  logic gen;
  assign gen = ({zero[0], pos[0]} != {zero[1], pos[1]}) &&
               ({zero[2], pos[2]} != {zero[3], pos[3]});
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      meet <= gen || |(zero & box_r);
    end
  end
endmodule

FILE: sv/segment_pair_clearance_test_core.sv
// Top level of the segment pair clearance test.
// Depends on spct_pkg, spct_cross, spct_dist and assert_macros.svh.
`timescale 1ns / 1ps
// One item can be accepted every cycle; its result is presented through four
// register stages: three arithmetic stages (products, compares, final product
// and combine) and an output register. Throughput is one pair per cycle,
// limited only by downstream ready; a stall freezes the whole pipeline in
// place.
`include "assert_macros.svh"
module segment_pair_clearance_test_core #(
  parameter int GRID_SIDE = spct_pkg::GridSideDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spct_pkg::SafeW-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spct_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spct_pkg::out_item_t           out_data
);
  localparam int CW = spct_pkg::CoordW;
  localparam logic [CW:0] MaxC = (CW + 1)'(GRID_SIDE - 1);

  logic [spct_pkg::SafeW-1:0] clear_dist;
  always_ff @(posedge clk) begin
    if (rst) clear_dist <= '0;
    else if (cfg_we) clear_dist <= cfg_data;
  end

  // Clamp coordinates to the grid.
  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
    return ({1'b0, v} > MaxC) ? MaxC[CW-1:0] : v;
  endfunction

  spct_pkg::in_item_t c;
  always_comb begin
    c.agent1_x = clamp(in_data.agent1_x);
    c.agent1_y = clamp(in_data.agent1_y);
    c.goal1_x  = clamp(in_data.goal1_x);
    c.goal1_y  = clamp(in_data.goal1_y);
    c.agent2_x = clamp(in_data.agent2_x);
    c.agent2_y = clamp(in_data.agent2_y);
    c.goal2_x  = clamp(in_data.goal2_x);
    c.goal2_y  = clamp(in_data.goal2_y);
  end

  // Pipeline advances whenever the output register can take a transfer.
  logic [2:0] vld;
  spct_pkg::pipe_ctrl_t ctrl;
  assign ctrl.adv = !out_valid || out_ready;
  assign in_ready = ctrl.adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (ctrl.adv) vld <= {vld[1:0], in_valid};
  end

  logic meet;
  spct_cross u_cross (.clk(clk), .ctrl(ctrl), .it(c), .meet(meet));

  logic [3:0] far;
  spct_dist u_d0 (.clk(clk), .ctrl(ctrl), .px(c.agent1_x), .py(c.agent1_y),
    .ax(c.agent2_x), .ay(c.agent2_y), .bx(c.goal2_x), .by(c.goal2_y),
    .s(clear_dist), .far(far[0]));
  spct_dist u_d1 (.clk(clk), .ctrl(ctrl), .px(c.goal1_x), .py(c.goal1_y),
    .ax(c.agent2_x), .ay(c.agent2_y), .bx(c.goal2_x), .by(c.goal2_y),
    .s(clear_dist), .far(far[1]));
  spct_dist u_d2 (.clk(clk), .ctrl(ctrl), .px(c.agent2_x), .py(c.agent2_y),
    .ax(c.agent1_x), .ay(c.agent1_y), .bx(c.goal1_x), .by(c.goal1_y),
    .s(clear_dist), .far(far[2]));
  spct_dist u_d3 (.clk(clk), .ctrl(ctrl), .px(c.goal2_x), .py(c.goal2_y),
    .ax(c.agent1_x), .ay(c.agent1_y), .bx(c.goal1_x), .by(c.goal1_y),
    .s(clear_dist), .far(far[3]));

  // Manhattan end distances, delayed to line up with the other results.
  function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [CW:0] da, dg;
  logic [2:1] close_d;
  logic [2:0] sz_d;
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      da <= {1'b0, adiff(c.agent1_x, c.agent2_x)} +
            {1'b0, adiff(c.agent1_y, c.agent2_y)};
      dg <= {1'b0, adiff(c.goal1_x, c.goal2_x)} +
            {1'b0, adiff(c.goal1_y, c.goal2_y)};
      sz_d[0]    <= clear_dist == '0;
      close_d[1] <= (da < clear_dist) && (dg < clear_dist);
      close_d[2] <= close_d[1];
      sz_d[2:1]  <= sz_d[1:0];
    end
  end

  // Output register.
  logic clear;
  assign clear = sz_d[2] || &far;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.adv) out_valid <= vld[2];
  end
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      out_data.separable       <= !close_d[2] && !meet && clear;
      out_data.segments_cross  <= meet;
      out_data.ends_both_close <= close_d[2];
      out_data.clearance_met   <= clear;
    end
  end

  `CHK_IMPL(a_sep_consistent, clk, rst, out_valid,
    out_data.separable == (!out_data.segments_cross &&
    !out_data.ends_both_close && out_data.clearance_met))
  `CHK_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_fill, clk, rst, vld[2] && ctrl.adv, out_valid)
endmodule
